@@ hw/rtl/swrs_pkg.sv @@
// Shared types and constants for the single-wire ROM search unit.
// No dependencies; every other file in hw/rtl imports this package.
package swrs_pkg;

	// Identifier geometry
	localparam int ID_BITS = 64;
	localparam int IDX_W   = $clog2(ID_BITS);
	localparam int POS_W   = 7;
	localparam int CNT_W   = 8;

	localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(ID_BITS);
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	// Command codes carried in the mode field
	localparam logic [1:0] MODE_NEW   = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_PAIR  = 2'd2;

	// Result status codes
	localparam logic [2:0] ST_CLEARED      = 3'd0;
	localparam logic [2:0] ST_STARTED      = 3'd1;
	localparam logic [2:0] ST_NO_PRESENCE  = 3'd2;
	localparam logic [2:0] ST_ALREADY_DONE = 3'd3;
	localparam logic [2:0] ST_DIRECTION    = 3'd4;
	localparam logic [2:0] ST_COMPLETE     = 3'd5;
	localparam logic [2:0] ST_NO_DEVICES   = 3'd6;
	localparam logic [2:0] ST_IGNORED      = 3'd7;

	typedef struct packed {
		logic [1:0] mode;
		logic       presence;
		logic       id_bit;
		logic       comp_bit;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         status;
		logic               write_bit;
		logic [ID_BITS-1:0] rom_id;
		logic [CNT_W-1:0]   dev_count;
		logic               search_done;
	} rsp_t;

endpackage

@@ hw/rtl/swrs_if.sv @@
// Valid/ready channel interfaces for the ROM search unit: command and result words.
// Depends on swrs_pkg for field widths.
interface swrs_cmd_if;
	import swrs_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic       presence;
	logic       id_bit;
	logic       comp_bit;

	modport source (output valid, output mode, output presence, output id_bit,
		output comp_bit, input ready);
	modport sink (input valid, input mode, input presence, input id_bit,
		input comp_bit, output ready);
endinterface

interface swrs_res_if;
	import swrs_pkg::*;

	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic               write_bit;
	logic [ID_BITS-1:0] rom_id;
	logic [CNT_W-1:0]   dev_count;
	logic               search_done;

	modport source (output valid, output status, output write_bit, output rom_id,
		output dev_count, output search_done, input ready);
	modport sink (input valid, input status, input write_bit, input rom_id,
		input dev_count, input search_done, output ready);
endinterface

@@ hw/rtl/swrs_engine.sv @@
// Search state and per-word decision logic of the ROM search unit.
// Depends on swrs_pkg; state advances on step, result is combinational.
module swrs_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  swrs_pkg::cmd_t cmd,
	output swrs_pkg::rsp_t rsp
);
	import swrs_pkg::*;

	logic [POS_W-1:0]   bit_pos_q, bit_pos_d;
	logic [POS_W-1:0]   disc_q, disc_d;
	logic [POS_W-1:0]   zmark_q, zmark_d;
	logic [ID_BITS-1:0] prev_id_q, prev_id_d;
	logic [ID_BITS-1:0] cur_id_q, cur_id_d;
	logic               done_q, done_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic               active_q, active_d;

	logic [POS_W-1:0] pos;
	logic [IDX_W-1:0] idx;
	logic             dir;

	// Clamp the position into 1..64 and derive the bit index
	always_comb begin
		if (bit_pos_q < POS_FIRST) begin
			pos = POS_FIRST;
		end else if (bit_pos_q > POS_LAST) begin
			pos = POS_LAST;
		end else begin
			pos = bit_pos_q;
		end
		idx = IDX_W'(pos - POS_FIRST);
	end

	// Decide status, direction and next state for one command word
	always_comb begin
		bit_pos_d = bit_pos_q;
		disc_d    = disc_q;
		zmark_d   = zmark_q;
		prev_id_d = prev_id_q;
		cur_id_d  = cur_id_q;
		done_d    = done_q;
		count_d   = count_q;
		active_d  = active_q;
		dir       = 1'b0;
		rsp       = '0;
		unique case (cmd.mode)
			MODE_NEW: begin
				bit_pos_d  = POS_FIRST;
				disc_d     = '0;
				zmark_d    = '0;
				prev_id_d  = '0;
				cur_id_d   = '0;
				done_d     = 1'b0;
				count_d    = '0;
				active_d   = 1'b0;
				rsp.status = ST_CLEARED;
			end
			MODE_START: begin
				if (!cmd.presence) begin
					active_d   = 1'b0;
					rsp.status = ST_NO_PRESENCE;
				end else if (done_q) begin
					rsp.status = ST_ALREADY_DONE;
				end else begin
					bit_pos_d  = POS_FIRST;
					zmark_d    = '0;
					cur_id_d   = '0;
					active_d   = 1'b1;
					rsp.status = ST_STARTED;
				end
			end
			MODE_PAIR: begin
				if (!active_q) begin
					rsp.status = ST_IGNORED;
				end else if (cmd.id_bit && cmd.comp_bit) begin
					active_d   = 1'b0;
					rsp.status = ST_NO_DEVICES;
				end else begin
					// Pick the branch: follow the bus, or resolve a discrepancy
					if (cmd.id_bit != cmd.comp_bit) begin
						dir = cmd.id_bit;
					end else if (pos == disc_q) begin
						dir = 1'b1;
					end else if (pos > disc_q) begin
						dir     = 1'b0;
						zmark_d = pos;
					end else begin
						dir = prev_id_q[idx];
						if (!dir) begin
							zmark_d = pos;
						end
					end
					cur_id_d[idx] = dir;
					rsp.write_bit = dir;
					if (pos != POS_LAST) begin
						bit_pos_d  = pos + POS_FIRST;
						rsp.status = ST_DIRECTION;
					end else begin
						// Close the pass and save its identifier
						disc_d = zmark_d;
						if (zmark_d == '0) begin
							done_d = 1'b1;
						end
						if (count_q != COUNT_MAX) begin
							count_d = count_q + CNT_W'(1);
						end
						prev_id_d  = cur_id_d;
						active_d   = 1'b0;
						bit_pos_d  = POS_FIRST;
						rsp.status = ST_COMPLETE;
						rsp.rom_id = cur_id_d;
					end
				end
			end
			default: begin
				rsp.status = ST_IGNORED;
			end
		endcase
		rsp.dev_count   = count_d;
		rsp.search_done = done_d;
	end

	// Advance the search state once per processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_pos_q <= POS_FIRST;
			disc_q    <= '0;
			zmark_q   <= '0;
			prev_id_q <= '0;
			cur_id_q  <= '0;
			done_q    <= 1'b0;
			count_q   <= '0;
			active_q  <= 1'b0;
		end else if (step) begin
			bit_pos_q <= bit_pos_d;
			disc_q    <= disc_d;
			zmark_q   <= zmark_d;
			prev_id_q <= prev_id_d;
			cur_id_q  <= cur_id_d;
			done_q    <= done_d;
			count_q   <= count_d;
			active_q  <= active_d;
		end
	end

endmodule

@@ hw/rtl/single_wire_rom_search_unit.sv @@
// Top level of the single-wire ROM search unit: input register, engine, result register.
// Depends on swrs_pkg, swrs_if (swrs_cmd_if, swrs_res_if) and swrs_engine.
//
// Usage:
//   cmd carries one command word: mode 0 starts a new enumeration, mode 1 opens
//   a pass with the presence result, mode 2 carries the id/complement bit pair
//   read for the current identifier position (least significant bit first).
//   res returns exactly one word per command: a status code, the direction bit
//   to write back (status direction or identifier complete), the identifier at
//   position 64, the device count so far and the enumeration-finished flag.
// Timing:
//   A command accepted into the input register is decided by the engine and its
//   result loaded into the result register, where the receiver can take it. One
//   command per cycle is sustained while res.ready is high; the search state
//   register updates in the same cycle the result register loads.
// Reset:
//   arst_n clears both stages and the search state (position 1, no saved
//   discrepancy, count zero, no pass in progress).
// Back-pressure:
//   While res.ready is low the result word is held; one more command is taken
//   into the input register, after which cmd.ready drops until the result moves.
module single_wire_rom_search_unit (
	input logic       clk,
	input logic       arst_n,
	swrs_cmd_if.sink   cmd,
	swrs_res_if.source res
);
	import swrs_pkg::*;

	logic s1_valid_q;
	cmd_t cmd_s1;
	logic res_valid_q;
	rsp_t rsp_q;
	rsp_t rsp_d;
	logic advance;

	assign advance   = s1_valid_q && (!res_valid_q || res.ready);
	assign cmd.ready = !s1_valid_q || advance;

	// Capture the incoming command word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= '{mode: cmd.mode, presence: cmd.presence, id_bit: cmd.id_bit,
				comp_bit: cmd.comp_bit};
		end
	end

	swrs_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cmd    (cmd_s1),
		.rsp    (rsp_d)
	);

	// Hold the result word until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.status      = rsp_q.status;
	assign res.write_bit   = rsp_q.write_bit;
	assign res.rom_id      = rsp_q.rom_id;
	assign res.dev_count   = rsp_q.dev_count;
	assign res.search_done = rsp_q.search_done;

`ifndef SYNTHESIS
	// An empty result register must never block the command side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> cmd.ready)
		else $error("cmd.ready low with empty result register");

	// The identifier is only reported with a completed pass
	a_id_only_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && rsp_q.status != ST_COMPLETE) |-> (rsp_q.rom_id == '0))
		else $error("rom_id nonzero outside identifier complete");

	// A direction bit appears only with direction or complete status
	a_dir_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && rsp_q.write_bit) |->
		(rsp_q.status == ST_DIRECTION || rsp_q.status == ST_COMPLETE))
		else $error("write_bit set with wrong status");
`endif

endmodule

@@ test/tb_single_wire_rom_search_unit.sv @@
// Self-checking bench for single_wire_rom_search_unit: simulated device buses drive
// full ROM searches plus noise, and a search predictor checks every result word.
// Depends on swrs_pkg, swrs_if and the RTL of the unit.
`timescale 1ns / 100ps

module tb_single_wire_rom_search_unit;
	import swrs_pkg::*;

	// mode value with no command behind it
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 1300;
	localparam int CROWD_SIZE   = 8;
	localparam int QUIET_LIMIT  = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int REPORT_LIMIT = 30;

	typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_style_t;
	typedef enum {BUS_EMPTY, BUS_CLUSTER, BUS_EDGE, BUS_SCATTER} bus_layout_t;

	logic clk;
	logic arst_n;

	swrs_cmd_if cmd_bus ();
	swrs_res_if res_bus ();

	single_wire_rom_search_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.res    (res_bus)
	);

	// command words still to be driven, and result words still owed by the unit
	cmd_t pending_words[$];
	rsp_t expected_results[$];

	// identifiers of the devices on the simulated bus
	logic [ID_BITS-1:0] bus_devices[$];

	// search state as the predictor sees it
	logic [POS_W-1:0]   srch_pos     = POS_FIRST;
	logic [POS_W-1:0]   srch_saved   = '0;
	logic [POS_W-1:0]   srch_marker  = '0;
	logic [ID_BITS-1:0] srch_prev_id = '0;
	logic [ID_BITS-1:0] srch_cur_id  = '0;
	logic               srch_done    = 1'b0;
	logic [CNT_W-1:0]   srch_found   = '0;
	logic               srch_in_pass = 1'b0;

	int error_count       = 0;
	int words_accepted    = 0;
	int results_seen      = 0;
	int ids_assembled     = 0;
	int enumerations_done = 0;
	int layouts_used      = 0;
	int peak_count        = 0;
	int quiet_cycles      = 0;

	// driver and receiver pacing
	cmd_t      drive_word;
	int        gap_left     = 0;
	int        burst_left   = 0;
	rx_style_t stall_style  = RX_OPEN;
	int        stall_left   = 0;
	int        stall_period = 2;
	rsp_t      exp_word;

	// clock, and known values on every input from time zero
	initial begin
		clk = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.mode = MODE_NEW;
		cmd_bus.presence = 1'b0;
		cmd_bus.id_bit = 1'b0;
		cmd_bus.comp_bit = 1'b0;
		res_bus.ready = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic cmd_t make_word(input logic [1:0] mode, input logic presence,
		input logic id_bit, input logic comp_bit);
		return {mode, presence, id_bit, comp_bit};
	endfunction

	function automatic cmd_t noise_word();
		return make_word(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom), 1'($urandom));
	endfunction

	// Predict the result of one word, then queue the word and its result.
	task automatic plan_word(input cmd_t w);
		rsp_t r;
		logic dir;
		int   idx;
		r = '0;
		if (w.mode == MODE_NEW) begin
			srch_pos = POS_FIRST;
			srch_saved = '0;
			srch_marker = '0;
			srch_prev_id = '0;
			srch_cur_id = '0;
			srch_done = 1'b0;
			srch_found = '0;
			srch_in_pass = 1'b0;
			r.status = ST_CLEARED;
		end else if (w.mode == MODE_START) begin
			if (!w.presence) begin
				srch_in_pass = 1'b0;
				r.status = ST_NO_PRESENCE;
			end else if (srch_done) begin
				r.status = ST_ALREADY_DONE;
			end else begin
				srch_pos = POS_FIRST;
				srch_marker = '0;
				srch_cur_id = '0;
				srch_in_pass = 1'b1;
				r.status = ST_STARTED;
			end
		end else if (w.mode != MODE_PAIR || !srch_in_pass) begin
			r.status = ST_IGNORED;
		end else if (w.id_bit && w.comp_bit) begin
			srch_in_pass = 1'b0;
			r.status = ST_NO_DEVICES;
		end else begin
			idx = int'(srch_pos) - 1;
			// pick the branch: forced by the bus, or chosen at a discrepancy
			if (w.id_bit != w.comp_bit) begin
				dir = w.id_bit;
			end else if (srch_pos == srch_saved) begin
				dir = 1'b1;
			end else if (srch_pos > srch_saved) begin
				dir = 1'b0;
				srch_marker = srch_pos;
			end else begin
				dir = srch_prev_id[idx];
				if (!dir)
					srch_marker = srch_pos;
			end
			srch_cur_id[idx] = dir;
			r.write_bit = dir;
			if (srch_pos < POS_LAST) begin
				srch_pos = srch_pos + 1'b1;
				r.status = ST_DIRECTION;
			end else begin
				// identifier complete: save the branch point for the next pass
				srch_saved = srch_marker;
				if (srch_saved == '0)
					srch_done = 1'b1;
				if (srch_found != COUNT_MAX)
					srch_found = srch_found + 1'b1;
				srch_prev_id = srch_cur_id;
				srch_in_pass = 1'b0;
				srch_pos = POS_FIRST;
				r.status = ST_COMPLETE;
				r.rom_id = srch_cur_id;
				ids_assembled++;
				if (srch_done)
					enumerations_done++;
			end
		end
		r.dev_count = srch_found;
		r.search_done = srch_done;
		if (int'(srch_found) > peak_count)
			peak_count = int'(srch_found);
		pending_words.push_back(w);
		expected_results.push_back(r);
	endtask

	// Wired-AND reply of the devices still on the path chosen so far.
	function automatic void bus_reply(input logic [POS_W-1:0] pos,
		input logic [ID_BITS-1:0] path, output logic id_bit, output logic comp_bit);
		logic [ID_BITS-1:0] mask;
		int idx;
		idx = int'(pos) - 1;
		mask = (64'd1 << idx) - 64'd1;
		id_bit = 1'b1;
		comp_bit = 1'b1;
		foreach (bus_devices[i]) begin
			if (((bus_devices[i] ^ path) & mask) == '0) begin
				id_bit &= bus_devices[i][idx];
				comp_bit &= ~bus_devices[i][idx];
			end
		end
	endfunction

	task automatic build_bus(input bus_layout_t layout);
		logic [ID_BITS-1:0] base;
		logic [ID_BITS-1:0] dev;
		int n;
		bus_devices.delete();
		base = {$urandom, $urandom};
		layouts_used++;
		case (layout)
			BUS_EMPTY: begin
			end
			// devices that share most bits, so branches fall deep and shallow
			BUS_CLUSTER: begin
				n = $urandom_range(2, 8);
				repeat (n) begin
					dev = base;
					repeat ($urandom_range(1, 3))
						dev[$urandom_range(0, ID_BITS - 1)] ^= 1'b1;
					bus_devices.push_back(dev);
				end
			end
			// identifier extremes and branches at the first and last position
			BUS_EDGE: begin
				case ($urandom_range(0, 4))
					0: bus_devices.push_back('0);
					1: bus_devices.push_back('1);
					2: begin
						bus_devices.push_back(base);
						bus_devices.push_back(base ^ 64'd1);
					end
					3: begin
						bus_devices.push_back(base);
						bus_devices.push_back(base ^ (64'd1 << (ID_BITS - 1)));
					end
					default: begin
						bus_devices.push_back('0);
						bus_devices.push_back('1);
					end
				endcase
			end
			default: begin
				n = $urandom_range(1, 10);
				repeat (n)
					bus_devices.push_back({$urandom, $urandom});
			end
		endcase
	endtask

	// Walk the bus through a full enumeration, with noise words mixed in.
	task automatic run_enumeration(input int noise_pm, input int budget);
		logic ib;
		logic cb;
		int   spent;
		spent = 0;
		plan_word(make_word(MODE_NEW, 1'($urandom), 1'($urandom), 1'($urandom)));
		while (spent < budget) begin
			spent++;
			if ($urandom_range(0, 999) < noise_pm) begin
				plan_word(noise_word());
			end else if (srch_in_pass) begin
				bus_reply(srch_pos, srch_cur_id, ib, cb);
				plan_word(make_word(MODE_PAIR, 1'($urandom), ib, cb));
			end else if (srch_done) begin
				// probe the finished state, then leave
				plan_word(make_word(MODE_START, 1'b1, 1'($urandom), 1'($urandom)));
				if ($urandom_range(0, 1))
					plan_word(make_word(MODE_START, 1'b0, 1'($urandom), 1'($urandom)));
				break;
			end else begin
				plan_word(make_word(MODE_START,
					(bus_devices.size() > 0) || ($urandom_range(0, 1) == 1),
					1'($urandom), 1'($urandom)));
			end
		end
	endtask

	// Build the whole stimulus, then wait for the unit to drain.
	initial begin
		int before_words;
		int random_words;
		int noise_pm;

		// directed words: every command and the abort and drop cases
		plan_word(make_word(MODE_NEW, 1'b0, 1'b0, 1'b0));
		plan_word(make_word(MODE_PAIR, 1'b0, 1'b1, 1'b0));
		plan_word(make_word(MODE_UNUSED, 1'b1, 1'b1, 1'b1));
		plan_word(make_word(MODE_START, 1'b0, 1'b0, 1'b0));
		plan_word(make_word(MODE_START, 1'b1, 1'b0, 1'b0));
		plan_word(make_word(MODE_PAIR, 1'b0, 1'b1, 1'b0));
		plan_word(make_word(MODE_PAIR, 1'b0, 1'b0, 1'b1));
		plan_word(make_word(MODE_PAIR, 1'b0, 1'b0, 1'b0));
		plan_word(make_word(MODE_START, 1'b1, 1'b1, 1'b1));
		plan_word(make_word(MODE_PAIR, 1'b1, 1'b0, 1'b0));
		plan_word(make_word(MODE_PAIR, 1'b0, 1'b1, 1'b1));
		plan_word(make_word(MODE_PAIR, 1'b0, 1'b0, 1'b1));
		plan_word(make_word(MODE_START, 1'b1, 1'b0, 1'b0));
		plan_word(make_word(MODE_PAIR, 1'b0, 1'b1, 1'b0));
		plan_word(make_word(MODE_START, 1'b0, 1'b1, 1'b1));
		plan_word(make_word(MODE_PAIR, 1'b0, 1'b0, 1'b0));
		plan_word(make_word(MODE_UNUSED, 1'b0, 1'b0, 1'b0));
		plan_word(make_word(MODE_NEW, 1'b1, 1'b1, 1'b1));
		plan_word(make_word(MODE_START, 1'b1, 1'b1, 1'b0));
		plan_word(make_word(MODE_PAIR, 1'b1, 1'b1, 1'b1));

		// one clean enumeration of a busier bus, back to back passes
		bus_devices.delete();
		repeat (CROWD_SIZE)
			bus_devices.push_back({$urandom, $urandom});
		layouts_used++;
		run_enumeration(0, 70 * (CROWD_SIZE + 3));

		// random bus layouts, mostly clean searches with some noise
		random_words = 0;
		while (random_words < RANDOM_WORDS) begin
			before_words = pending_words.size();
			noise_pm = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(5, 20))
					plan_word(noise_word());
			end else begin
				build_bus(bus_layout_t'($urandom_range(0, 3)));
				run_enumeration(noise_pm,
					(bus_devices.size() == 0) ? 8 : 70 * (bus_devices.size() + 3));
			end
			random_words += pending_words.size() - before_words;
		end

		while (pending_words.size() > 0 || expected_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d command words over %0d bus layouts, %0d results checked.",
			words_accepted, layouts_used, results_seen);
		$display("Assembled %0d identifiers, %0d enumerations finished, count peaked at %0d.",
			ids_assembled, enumerations_done, peak_count);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Drive command words in bursts separated by random gaps.
	always @(posedge clk) begin
		if (arst_n && (!cmd_bus.valid || cmd_bus.ready)) begin
			if (gap_left > 0) begin
				gap_left--;
				cmd_bus.valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				drive_word = pending_words.pop_front();
				cmd_bus.mode <= drive_word.mode;
				cmd_bus.presence <= drive_word.presence;
				cmd_bus.id_bit <= drive_word.id_bit;
				cmd_bus.comp_bit <= drive_word.comp_bit;
				cmd_bus.valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 47);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				cmd_bus.valid <= 1'b0;
			end
		end
	end

	// Stall the result side in phases of differing pressure.
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left == 0) begin
				stall_style = rx_style_t'($urandom_range(0, 3));
				stall_left = $urandom_range(16, 160);
				stall_period = $urandom_range(2, 9);
			end else begin
				stall_left--;
			end
			case (stall_style)
				RX_OPEN:  res_bus.ready <= 1'b1;
				RX_LIGHT: res_bus.ready <= ($urandom_range(0, 3) != 0);
				RX_HEAVY: res_bus.ready <= ($urandom_range(0, 3) == 0);
				default:  res_bus.ready <= (stall_left % stall_period == 0);
			endcase
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			error_count++;
			if (error_count <= REPORT_LIMIT)
				$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// Compare each accepted result word with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (expected_results.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("%0t: result word with none expected: status %0h", $time,
						res_bus.status);
			end else begin
				exp_word = expected_results.pop_front();
				results_seen++;
				check_field("status", 64'(exp_word.status), 64'(res_bus.status));
				check_field("write_bit", 64'(exp_word.write_bit), 64'(res_bus.write_bit));
				check_field("rom_id", exp_word.rom_id, res_bus.rom_id);
				check_field("dev_count", 64'(exp_word.dev_count), 64'(res_bus.dev_count));
				check_field("search_done", 64'(exp_word.search_done),
					64'(res_bus.search_done));
			end
		end
	end

	// Count handshakes; end the run if both channels stay quiet too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_bus.valid && cmd_bus.ready)
				words_accepted++;
			if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

endmodule
